[design/msh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msh_pkg;

    localparam int DIM_W    = 14;
    localparam int CODED_W  = 15;
    localparam int TOTAL_W  = 24;
    localparam int HDR_KEEP = 6;
    localparam int MIN_HDR  = 6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [23:0]        START_PREFIX = 24'h000001;
    localparam logic [23:0]        WINDOW_INIT  = 24'hFFFFFF;

    localparam logic [7:0] SC_PIC = 8'h00;
    localparam logic [7:0] SC_SEQ = 8'hB3;
    localparam logic [7:0] SC_EXT = 8'hB5;

    localparam logic [3:0] EXT_ID_SEQ = 4'h1;
    localparam logic [3:0] EXT_ID_PIC = 4'h8;
    localparam logic [1:0] PIC_FRAME  = 2'b11;
    localparam logic [1:0] CHROMA_420 = 2'd1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SEQ  = 2'd1,
        KIND_EXT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic             seen_seq;
        logic             seen_ext;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [3:0]       rate_code;
        logic [1:0]       rate_num;
        logic [4:0]       rate_den;
        logic             prog;
        logic [1:0]       chroma;
    } msh_snap_t;

endpackage

`default_nettype wire

[design/msh_byte_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module msh_byte_parser
    import msh_pkg::*;
#(
    parameter int HEADER_DEPTH = 8,
    parameter int COUNT_BITS   = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  stream_end,
    output logic                       snap_valid,
    input  wire logic                  snap_ready,
    output msh_snap_t                  snap,
    output logic [COUNT_BITS-1:0]      snap_frames,
    output logic [COUNT_BITS-1:0]      snap_fields
);

    localparam int CNT_W = $clog2(HEADER_DEPTH + 1);
    localparam int SUM_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  in_valid_reg;
    logic [7:0]            byte_reg;
    logic                  end_reg;

    logic [23:0]           window_reg;
    kind_t                 kind_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [7:0]            hdr_reg [HDR_KEEP];
    logic                  seen_seq_reg;
    logic                  seen_ext_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [3:0]            rc_reg;
    logic [1:0]            num_reg;
    logic [4:0]            den_reg;
    logic                  prog_reg;
    logic [1:0]            chroma_reg;
    logic                  open_reg;
    logic [COUNT_BITS-1:0] frame_reg;
    logic [COUNT_BITS-1:0] field_reg;

    logic                  snap_valid_reg;
    msh_snap_t             snap_reg;
    logic [COUNT_BITS-1:0] snap_frames_reg;
    logic [COUNT_BITS-1:0] snap_fields_reg;

    kind_t                 kind_next;
    logic [CNT_W-1:0]      count_next;
    logic [7:0]            hdr_next [HDR_KEEP];
    logic                  seen_seq_next;
    logic                  seen_ext_next;
    logic [DIM_W-1:0]      width_next;
    logic [DIM_W-1:0]      height_next;
    logic [3:0]            rc_next;
    logic [1:0]            num_next;
    logic [4:0]            den_next;
    logic                  prog_next;
    logic [1:0]            chroma_next;
    logic                  open_next;
    logic [COUNT_BITS-1:0] frame_next;
    logic [COUNT_BITS-1:0] field_next;

    logic                  fire;
    logic                  snap_free;
    logic                  collecting;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  full;
    logic                  is_code;
    logic                  parse;
    logic [3:0]            ext_id;
    logic                  seq_take;
    logic                  ext_take;
    logic                  pic_ext;
    logic                  as_frame;
    logic                  close_a;
    logic                  open1;
    logic                  pic_start;
    logic                  close_b;
    logic                  open2;
    logic                  close_c;
    logic [1:0]            frame_add;
    logic [SUM_W-1:0]      frame_sum;

    assign snap_free  = !snap_valid_reg || snap_ready;
    assign fire       = in_valid_reg && (!end_reg || snap_free);
    assign byte_stall = in_valid_reg && !fire;

    always_comb
    begin
        collecting = kind_reg != KIND_NONE;
        cnt_inc    = count_reg + 1'b1;
        for (int i = 0; i < HDR_KEEP; i++)
        begin
            hdr_next[i] = (collecting && count_reg == CNT_W'(i)) ? byte_reg : hdr_reg[i];
        end
        full    = collecting && (cnt_inc >= CNT_W'(HEADER_DEPTH));
        is_code = window_reg == START_PREFIX;
        parse   = collecting && (full || ((is_code || end_reg) && cnt_inc >= CNT_W'(MIN_HDR)));

        ext_id   = hdr_next[0][7:4];
        seq_take = parse && kind_reg == KIND_SEQ && !seen_seq_reg;
        ext_take = parse && kind_reg == KIND_EXT && ext_id == EXT_ID_SEQ
                   && seen_seq_reg && !seen_ext_reg;
        pic_ext  = parse && kind_reg == KIND_EXT && ext_id == EXT_ID_PIC;
        as_frame = hdr_next[2][1:0] == PIC_FRAME;

        close_a   = pic_ext && open_reg;
        open1     = open_reg && !close_a;
        pic_start = is_code && byte_reg == SC_PIC;
        close_b   = pic_start && open1;
        open2     = pic_start || open1;
        close_c   = end_reg && open2;
        open_next = open2;

        frame_add  = {1'b0, close_a && as_frame} + {1'b0, close_b} + {1'b0, close_c};
        frame_sum  = {1'b0, frame_reg} + SUM_W'(frame_add);
        frame_next = (frame_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : frame_sum[COUNT_BITS-1:0];
        field_next = (close_a && !as_frame && field_reg != COUNT_MAX)
                     ? field_reg + 1'b1 : field_reg;

        seen_seq_next = seen_seq_reg || seq_take;
        seen_ext_next = seen_ext_reg || ext_take;
        width_next    = width_reg;
        height_next   = height_reg;
        rc_next       = rc_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        prog_next     = prog_reg;
        chroma_next   = chroma_reg;
        if (seq_take)
        begin
            width_next  = {2'b00, hdr_next[0], hdr_next[1][7:4]};
            height_next = {2'b00, hdr_next[1][3:0], hdr_next[2]};
            rc_next     = hdr_next[3][3:0];
        end
        if (ext_take)
        begin
            width_next  = width_reg | {hdr_next[1][0], hdr_next[2][7], 12'b0};
            height_next = height_reg | {hdr_next[2][6:5], 12'b0};
            prog_next   = hdr_next[1][3];
            chroma_next = hdr_next[1][2:1];
            num_next    = hdr_next[5][6:5];
            den_next    = hdr_next[5][4:0];
        end

        if (is_code)
        begin
            case (byte_reg)
                SC_SEQ:
                begin
                    kind_next  = KIND_SEQ;
                    count_next = '0;
                end
                SC_EXT:
                begin
                    kind_next  = KIND_EXT;
                    count_next = '0;
                end
                default:
                begin
                    kind_next  = KIND_NONE;
                    count_next = collecting ? cnt_inc : count_reg;
                end
            endcase
        end
        else
        begin
            kind_next  = full ? KIND_NONE : kind_reg;
            count_next = collecting ? cnt_inc : count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            window_reg     <= WINDOW_INIT;
            kind_reg       <= KIND_NONE;
            count_reg      <= '0;
            seen_seq_reg   <= 1'b0;
            seen_ext_reg   <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            rc_reg         <= '0;
            num_reg        <= '0;
            den_reg        <= '0;
            prog_reg       <= 1'b1;
            chroma_reg     <= CHROMA_420;
            open_reg       <= 1'b0;
            frame_reg      <= '0;
            field_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire && end_reg)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                snap_valid_reg <= 1'b0;
            end

            if (fire && end_reg)
            begin
                window_reg   <= WINDOW_INIT;
                kind_reg     <= KIND_NONE;
                count_reg    <= '0;
                seen_seq_reg <= 1'b0;
                seen_ext_reg <= 1'b0;
                width_reg    <= '0;
                height_reg   <= '0;
                rc_reg       <= '0;
                num_reg      <= '0;
                den_reg      <= '0;
                prog_reg     <= 1'b1;
                chroma_reg   <= CHROMA_420;
                open_reg     <= 1'b0;
                frame_reg    <= '0;
                field_reg    <= '0;
            end
            else if (fire)
            begin
                window_reg   <= {window_reg[15:0], byte_reg};
                kind_reg     <= kind_next;
                count_reg    <= count_next;
                seen_seq_reg <= seen_seq_next;
                seen_ext_reg <= seen_ext_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                rc_reg       <= rc_next;
                num_reg      <= num_next;
                den_reg      <= den_next;
                prog_reg     <= prog_next;
                chroma_reg   <= chroma_next;
                open_reg     <= open_next;
                frame_reg    <= frame_next;
                field_reg    <= field_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            byte_reg <= data_byte;
            end_reg  <= stream_end;
        end
        if (fire)
        begin
            hdr_reg <= hdr_next;
        end
        if (fire && end_reg)
        begin
            snap_reg.seen_seq  <= seen_seq_next;
            snap_reg.seen_ext  <= seen_ext_next;
            snap_reg.width     <= width_next;
            snap_reg.height    <= height_next;
            snap_reg.rate_code <= rc_next;
            snap_reg.rate_num  <= num_next;
            snap_reg.rate_den  <= den_next;
            snap_reg.prog      <= prog_next;
            snap_reg.chroma    <= chroma_next;
            snap_frames_reg    <= frame_next;
            snap_fields_reg    <= field_next;
        end
    end

    assign snap_valid  = snap_valid_reg;
    assign snap        = snap_reg;
    assign snap_frames = snap_frames_reg;
    assign snap_fields = snap_fields_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HEADER_DEPTH))
        else $error("header byte count beyond header depth");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_reg |=> kind_reg == KIND_NONE && !seen_seq_reg && !open_reg
                            && frame_reg == '0 && field_reg == '0)
        else $error("state not cleared after final byte");

    a_snap_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(snap_valid_reg) |-> $past(fire && end_reg))
        else $error("snapshot without a final byte");

endmodule

`default_nettype wire

[design/msh_result_fmt.sv]
`timescale 1ns / 1ps
`default_nettype none

module msh_result_fmt
    import msh_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  snap_valid,
    output logic                       snap_ready,
    input  wire msh_snap_t             snap,
    input  wire logic [COUNT_BITS-1:0] snap_frames,
    input  wire logic [COUNT_BITS-1:0] snap_fields,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic                       format_ok,
    output logic                       is_mpeg2,
    output logic                       progressive,
    output logic [1:0]                 chroma_code,
    output logic [DIM_W-1:0]           pic_width,
    output logic [DIM_W-1:0]           pic_height,
    output logic [CODED_W-1:0]         padded_width,
    output logic [CODED_W-1:0]         padded_height,
    output logic [3:0]                 rate_code,
    output logic [1:0]                 rate_ext_num,
    output logic [4:0]                 rate_ext_den,
    output logic [TOTAL_W-1:0]         frame_total
);

    localparam int SUM_W = (COUNT_BITS + 1 > TOTAL_W + 1) ? COUNT_BITS + 1 : TOTAL_W + 1;

    logic                 valid_reg;
    logic                 ok_reg;
    logic                 mpeg2_reg;
    logic                 prog_reg;
    logic [1:0]           chroma_reg;
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [CODED_W-1:0]   cw_reg;
    logic [CODED_W-1:0]   ch_reg;
    logic [3:0]           rc_reg;
    logic [1:0]           num_reg;
    logic [4:0]           den_reg;
    logic [TOTAL_W-1:0]   total_reg;

    logic                 load;
    logic                 ok;
    logic                 prog;
    logic [CODED_W-1:0]   w_pad;
    logic [CODED_W-1:0]   h_pad16;
    logic [CODED_W-1:0]   h_pad32;
    logic [SUM_W-1:0]     total_sum;
    logic [TOTAL_W-1:0]   total_sat;

    assign snap_ready = !valid_reg || !result_stall;
    assign load       = snap_valid && snap_ready;

    always_comb
    begin
        ok        = snap.seen_seq && snap.width != '0 && snap.height != '0;
        prog      = !snap.seen_ext || snap.prog;
        w_pad     = {1'b0, snap.width} + CODED_W'(15);
        h_pad16   = {1'b0, snap.height} + CODED_W'(15);
        h_pad32   = {1'b0, snap.height} + CODED_W'(31);
        total_sum = SUM_W'(snap_frames) + SUM_W'(snap_fields >> 1);
        total_sat = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg     <= ok;
            mpeg2_reg  <= ok && snap.seen_ext;
            prog_reg   <= ok && prog;
            chroma_reg <= ok ? snap.chroma : 2'd0;
            width_reg  <= ok ? snap.width : '0;
            height_reg <= ok ? snap.height : '0;
            cw_reg     <= ok ? {w_pad[CODED_W-1:4], 4'b0} : '0;
            ch_reg     <= !ok ? '0 : prog ? {h_pad16[CODED_W-1:4], 4'b0}
                                          : {h_pad32[CODED_W-1:5], 5'b0};
            rc_reg     <= ok ? snap.rate_code : 4'd0;
            num_reg    <= ok ? snap.rate_num : 2'd0;
            den_reg    <= ok ? snap.rate_den : 5'd0;
            total_reg  <= ok ? total_sat : '0;
        end
    end

    assign result_valid  = valid_reg;
    assign format_ok     = ok_reg;
    assign is_mpeg2      = mpeg2_reg;
    assign progressive   = prog_reg;
    assign chroma_code   = chroma_reg;
    assign pic_width     = width_reg;
    assign pic_height    = height_reg;
    assign padded_width  = cw_reg;
    assign padded_height = ch_reg;
    assign rate_code     = rc_reg;
    assign rate_ext_num  = num_reg;
    assign rate_ext_den  = den_reg;
    assign frame_total   = total_reg;

    a_bad_format_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ok_reg |-> width_reg == '0 && height_reg == '0 && total_reg == '0
                                 && !mpeg2_reg && !prog_reg && chroma_reg == 2'd0)
        else $error("invalid format carries nonzero fields");

    a_coded_size: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ok_reg |-> cw_reg[3:0] == 4'd0 && cw_reg >= {1'b0, width_reg}
                                && ch_reg >= {1'b0, height_reg})
        else $error("coded size not aligned or below display size");

endmodule

`default_nettype wire

[design/mpeg_stream_header_probe_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// MPEG-1/2 video elementary stream header probe. Takes one stream byte per
// clock on the byte channel and returns one summary transaction for each byte
// marked stream_end, after which all parse state starts over. A byte goes
// through an input register, the start-code and header parse logic that
// updates the stream state, a snapshot register and the formatting output
// register, in that order. Bytes keep flowing while a summary waits; only a
// second final byte holds off until the snapshot register frees up.
// HEADER_DEPTH sets how many bytes at most after a header start code are
// gathered before parsing, COUNT_BITS the width of the frame and field
// counters.
module mpeg_stream_header_probe_top
    import msh_pkg::*;
#(
    parameter int HEADER_DEPTH = 8,
    parameter int COUNT_BITS   = 24
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire logic [7:0]          data_byte,
    input  wire logic                stream_end,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     format_ok,
    output logic                     is_mpeg2,
    output logic                     progressive,
    output logic [1:0]               chroma_code,
    output logic [DIM_W-1:0]         pic_width,
    output logic [DIM_W-1:0]         pic_height,
    output logic [CODED_W-1:0]       padded_width,
    output logic [CODED_W-1:0]       padded_height,
    output logic [3:0]               rate_code,
    output logic [1:0]               rate_ext_num,
    output logic [4:0]               rate_ext_den,
    output logic [TOTAL_W-1:0]       frame_total
);

    logic                  snap_valid;
    logic                  snap_ready;
    msh_snap_t             snap;
    logic [COUNT_BITS-1:0] snap_frames;
    logic [COUNT_BITS-1:0] snap_fields;

    msh_byte_parser #(
        .HEADER_DEPTH (HEADER_DEPTH),
        .COUNT_BITS   (COUNT_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap),
        .snap_frames (snap_frames),
        .snap_fields (snap_fields)
    );

    msh_result_fmt #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fmt (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap_ready    (snap_ready),
        .snap          (snap),
        .snap_frames   (snap_frames),
        .snap_fields   (snap_fields),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .format_ok     (format_ok),
        .is_mpeg2      (is_mpeg2),
        .progressive   (progressive),
        .chroma_code   (chroma_code),
        .pic_width     (pic_width),
        .pic_height    (pic_height),
        .padded_width  (padded_width),
        .padded_height (padded_height),
        .rate_code     (rate_code),
        .rate_ext_num  (rate_ext_num),
        .rate_ext_den  (rate_ext_den),
        .frame_total   (frame_total)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import msh_pkg::*;

    localparam int          HDR_DEPTH   = 8;
    localparam logic [23:0] COUNT_MAX   = '1;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          MAX_REPORTS = 40;

    typedef struct {
        logic               fmt;
        logic               mp2;
        logic               prog;
        logic [1:0]         chroma;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [CODED_W-1:0] cw;
        logic [CODED_W-1:0] ch;
        logic [3:0]         rc;
        logic [1:0]         rn;
        logic [4:0]         rd;
        logic [TOTAL_W-1:0] total;
    } summary_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         pause;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               byte_valid = 1'b0;
    logic               byte_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               stream_end = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               format_ok;
    logic               is_mpeg2;
    logic               progressive;
    logic [1:0]         chroma_code;
    logic [DIM_W-1:0]   pic_width;
    logic [DIM_W-1:0]   pic_height;
    logic [CODED_W-1:0] padded_width;
    logic [CODED_W-1:0] padded_height;
    logic [3:0]         rate_code;
    logic [1:0]         rate_ext_num;
    logic [4:0]         rate_ext_den;
    logic [TOTAL_W-1:0] frame_total;

    mpeg_stream_header_probe_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .stream_end   (stream_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .format_ok    (format_ok),
        .is_mpeg2     (is_mpeg2),
        .progressive  (progressive),
        .chroma_code  (chroma_code),
        .pic_width    (pic_width),
        .pic_height   (pic_height),
        .padded_width (padded_width),
        .padded_height(padded_height),
        .rate_code    (rate_code),
        .rate_ext_num (rate_ext_num),
        .rate_ext_den (rate_ext_den),
        .frame_total  (frame_total)
    );

    always #5 clk = ~clk;

    byte_item_t  pend_q[$];
    summary_t    summary_q[$];

    int          phase = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned formats_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int          hold_wait = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // stream state of the probe
    logic [23:0] win;
    kind_t       kind;
    logic [7:0]  hdr[HDR_DEPTH];
    int unsigned hdr_n;
    bit          got_seq;
    bit          got_ext;
    logic [13:0] wid;
    logic [13:0] hgt;
    logic [3:0]  rcode;
    logic [1:0]  rnum;
    logic [4:0]  rden;
    bit          prog_flag;
    logic [1:0]  chroma;
    bit          pic_open;
    logic [23:0] frames;
    logic [23:0] fields;

    function automatic void stream_reset();
        win = WINDOW_INIT;
        kind = KIND_NONE;
        foreach (hdr[i])
            hdr[i] = 8'h00;
        hdr_n = 0;
        got_seq = 1'b0;
        got_ext = 1'b0;
        wid = '0;
        hgt = '0;
        rcode = '0;
        rnum = '0;
        rden = '0;
        prog_flag = 1'b1;
        chroma = CHROMA_420;
        pic_open = 1'b0;
        frames = '0;
        fields = '0;
    endfunction

    function automatic void close_picture(bit as_frame);
        if (!pic_open)
            return;
        pic_open = 1'b0;
        if (as_frame)
        begin
            if (frames != COUNT_MAX)
                frames++;
        end
        else if (fields != COUNT_MAX)
            fields++;
    endfunction

    function automatic void parse_collected();
        if (kind == KIND_SEQ && !got_seq)
        begin
            got_seq = 1'b1;
            wid = {2'b00, hdr[0], hdr[1][7:4]};
            hgt = {2'b00, hdr[1][3:0], hdr[2]};
            rcode = hdr[3][3:0];
        end
        else if (kind == KIND_EXT)
        begin
            if (hdr[0][7:4] == EXT_ID_SEQ && got_seq && !got_ext)
            begin
                got_ext = 1'b1;
                prog_flag = hdr[1][3];
                chroma = hdr[1][2:1];
                wid[13:12] = wid[13:12] | {hdr[1][0], hdr[2][7]};
                hgt[13:12] = hgt[13:12] | hdr[2][6:5];
                rnum = hdr[5][6:5];
                rden = hdr[5][4:0];
            end
            else if (hdr[0][7:4] == EXT_ID_PIC)
                close_picture(hdr[2][1:0] == PIC_FRAME);
        end
    endfunction

    function automatic void take_stream_byte(logic [7:0] b);
        bit is_code;
        if (kind != KIND_NONE)
        begin
            if (hdr_n < HDR_DEPTH)
                hdr[hdr_n] = b;
            hdr_n++;
            if (hdr_n >= HDR_DEPTH)
            begin
                parse_collected();
                kind = KIND_NONE;
            end
        end
        is_code = (win == START_PREFIX);
        win = {win[15:0], b};
        if (is_code)
        begin
            if (kind != KIND_NONE && hdr_n >= MIN_HDR)
                parse_collected();
            kind = KIND_NONE;
            if (b == SC_PIC)
            begin
                close_picture(1'b1);
                pic_open = 1'b1;
            end
            else if (b == SC_SEQ || b == SC_EXT)
            begin
                kind = (b == SC_SEQ) ? KIND_SEQ : KIND_EXT;
                hdr_n = 0;
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        summary_t    s;
        bit          p;
        logic [31:0] total;
        take_stream_byte(b);
        if (!last)
            return;
        if (kind != KIND_NONE && hdr_n >= MIN_HDR)
            parse_collected();
        close_picture(1'b1);
        s = '{default: '0};
        if (got_seq && wid != 0 && hgt != 0)
        begin
            p = !got_ext || prog_flag;
            total = 32'(frames) + 32'(fields >> 1);
            if (total > 32'(TOTAL_MAX))
                total = 32'(TOTAL_MAX);
            s.fmt = 1'b1;
            s.mp2 = got_ext;
            s.prog = p;
            s.chroma = chroma;
            s.w = wid;
            s.h = hgt;
            s.cw = CODED_W'((int'(wid) + 15) / 16 * 16);
            s.ch = p ? CODED_W'((int'(hgt) + 15) / 16 * 16)
                     : CODED_W'((int'(hgt) + 31) / 32 * 32);
            s.rc = rcode;
            s.rn = rnum;
            s.rd = rden;
            s.total = total[TOTAL_W-1:0];
        end
        summary_q.push_back(s);
        stream_reset();
    endfunction

    initial stream_reset();

    function automatic void push_stream(logic [7:0] s[$]);
        byte_item_t it;
        foreach (s[i])
        begin
            it.data = s[i];
            it.last = (i == s.size() - 1);
            it.pause = 1'b0;
            pend_q.push_back(it);
            bytes_queued++;
        end
    endfunction

    function automatic void push_pause();
        byte_item_t it;
        it.data = 8'h00;
        it.last = 1'b0;
        it.pause = 1'b1;
        pend_q.push_back(it);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 25)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void add_header(ref logic [7:0] s[$], input logic [7:0] code,
                                       input logic [7:0] first);
        int len;
        int base;
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            len = HDR_DEPTH + $urandom_range(0, 2);
        else if (r < 88)
            len = $urandom_range(MIN_HDR - 1, HDR_DEPTH - 1);
        else
            len = $urandom_range(1, MIN_HDR - 2);
        s = {s, 8'h00, 8'h00, 8'h01, code};
        base = s.size();
        s.push_back(first);
        repeat (len - 1)
            s.push_back(pick_byte());
        // force a zero size now and then
        if (code == SC_SEQ && len >= 3 && $urandom_range(0, 7) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                s[base] = 8'h00;
                s[base + 1][7:4] = 4'h0;
            end
            else
            begin
                s[base + 1][3:0] = 4'h0;
                s[base + 2] = 8'h00;
            end
        end
    endfunction

    task automatic gen_stream();
        logic [7:0] s[$];
        int         flavor;
        flavor = $urandom_range(0, 99);
        repeat ($urandom_range(0, 3))
            s.push_back(pick_byte());
        if (flavor < 12)
        begin
            repeat ($urandom_range(3, 30))
            begin
                if ($urandom_range(0, 7) == 0)
                    s = {s, 8'h00, 8'h00, 8'h01};
                s.push_back(pick_byte());
            end
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                add_header(s, SC_EXT, {EXT_ID_SEQ, 4'($urandom)});
            if ($urandom_range(0, 19) != 0)
                add_header(s, SC_SEQ, pick_byte());
            if ($urandom_range(0, 9) == 0)
                add_header(s, SC_SEQ, pick_byte());
            if ($urandom_range(0, 9) < 6)
                add_header(s, SC_EXT, {EXT_ID_SEQ, 4'($urandom)});
            if ($urandom_range(0, 9) == 0)
                add_header(s, SC_EXT, {EXT_ID_SEQ, 4'($urandom)});
            if ($urandom_range(0, 9) == 0)
                add_header(s, SC_EXT, {EXT_ID_PIC, 4'($urandom)});
            repeat ($urandom_range(0, 4))
            begin
                s = {s, 8'h00, 8'h00, 8'h01, SC_PIC};
                repeat ($urandom_range(1, 4))
                    s.push_back(pick_byte());
                if ($urandom_range(0, 9) < 7)
                    add_header(s, SC_EXT, {EXT_ID_PIC, 4'($urandom)});
                else if ($urandom_range(0, 2) == 0)
                    add_header(s, SC_EXT, 8'($urandom));
            end
        end
        if (s.size() == 0 || $urandom_range(0, 3) == 0)
            s.push_back(pick_byte());
        push_stream(s);
    endtask

    // present one byte per transaction, predict on acceptance
    always @(posedge clk)
    begin : drive
        byte_item_t nxt;
        if (!rst_n)
            byte_valid <= 1'b0;
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                predict_byte(data_byte, stream_end);
                bytes_sent++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (pend_q.size() != 0 && pend_q[0].pause && summary_q.size() == 0)
                    void'(pend_q.pop_front());
                if (pend_q.size() != 0 && !pend_q[0].pause
                    && $urandom_range(0, 99) >= send_idle)
                begin
                    nxt = pend_q.pop_front();
                    byte_valid <= 1'b1;
                    data_byte <= nxt.data;
                    stream_end <= nxt.last;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : receive
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (phase == 2 && !hold_done)
            begin
                if (hold_wait == 60)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                else
                    hold_wait++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        summary_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (summary_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: summary transaction with none expected, expected none, actual %0d",
                         $time, frame_total);
            end
            else
            begin
                want = summary_q.pop_front();
                if (want.fmt)
                    formats_seen++;
                check_field("format_ok", want.fmt, format_ok);
                check_field("is_mpeg2", want.mp2, is_mpeg2);
                check_field("progressive", want.prog, progressive);
                check_field("chroma_code", want.chroma, chroma_code);
                check_field("pic_width", want.w, pic_width);
                check_field("pic_height", want.h, pic_height);
                check_field("padded_width", want.cw, padded_width);
                check_field("padded_height", want.ch, padded_height);
                check_field("rate_code", want.rc, rate_code);
                check_field("rate_ext_num", want.rn, rate_ext_num);
                check_field("rate_ext_den", want.rd, rate_ext_den);
                check_field("frame_total", want.total, frame_total);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d summaries outstanding",
                     cycles, summary_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  s[$];
        int unsigned target;
        bit          paused;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // no header at all
        s = {8'hFF};
        push_stream(s);
        // largest sequence header sizes, header parsed at stream end with six bytes
        s = {8'h00, 8'h00, 8'h01, SC_SEQ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        push_stream(s);
        // short header dropped
        s = {8'h00, 8'h00, 8'h01, SC_SEQ, 8'h10, 8'h00, 8'h01};
        push_stream(s);
        // picture without sequence header
        s = {8'h00, 8'h00, 8'h01, SC_PIC};
        push_stream(s);

        for (int ph = 0; ph < 3; ph++)
        begin
            while (pend_q.size() != 0)
                @(negedge clk);
            phase = ph;
            send_idle = (ph == 0) ? 37 : (ph == 1) ? 59 : 0;
            recv_idle = (ph == 0) ? 59 : (ph == 1) ? 37 : 0;
            target = bytes_queued + ((ph == 2) ? 700 : 650);
            paused = 1'b0;
            while (bytes_queued < target)
            begin
                gen_stream();
                if (!paused && bytes_queued + 325 >= target)
                begin
                    push_pause();
                    paused = 1'b1;
                end
            end
        end

        while (pend_q.size() != 0 || byte_valid)
            @(negedge clk);
        while (summary_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d stream bytes, checked %0d stream summaries (%0d with a valid format)",
                 bytes_sent, results_seen, formats_seen);
        $display("Idle mixes on both channels, a long output hold-off and a drain pause");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/msh_pkg.sv
design/msh_byte_parser.sv
design/msh_result_fmt.sv
design/mpeg_stream_header_probe_top.sv
sim/tb_top.sv
